// ===== sv/k_smallest_max_heap_macros.svh =====
// Assertion macros shared by the k-smallest max-heap RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef K_SMALLEST_MAX_HEAP_MACROS_SVH
`define K_SMALLEST_MAX_HEAP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define KSH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define KSH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ksh_pkg.sv =====
// Package for the k-smallest max-heap block: field widths, codes, defaults.
// No dependencies; imported by the interfaces and the top level.
package ksh_pkg;

    // Fixed transaction field widths
    localparam int OP_W   = 2;
    localparam int VAL_W  = 32;
    localparam int IDX_W  = 6;
    localparam int KCFG_W = 7;
    localparam int ST_W   = 2;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_K      = 64;
    localparam int DEF_VALUE_BITS = 32;

    // Heap size after reset
    localparam logic [KCFG_W-1:0] K_RESET = 7'd64;

    typedef logic [OP_W-1:0] t_op;
    typedef logic [ST_W-1:0] t_status;

    // Operation codes
    localparam t_op OP_LOAD  = 2'd0;
    localparam t_op OP_OFFER = 2'd1;
    localparam t_op OP_READ  = 2'd2;

    // Result status codes
    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_REJECT = 2'd1;
    localparam t_status ST_MISUSE = 2'd2;

endpackage

// ===== sv/ksh_item_if.sv =====
// Input channel of the k-smallest max-heap: valid/ready plus op, value, index.
// Depends on ksh_pkg.
interface ksh_item_if
    import ksh_pkg::*;
    ();
    logic             valid;
    logic             ready;
    t_op              op;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;

    modport source (output valid, output op, output value, output index, input ready);
    modport sink   (input valid, input op, input value, input index, output ready);
endinterface

// ===== sv/ksh_res_if.sv =====
// Result channel of the k-smallest max-heap: valid/ready plus the result fields.
// Depends on ksh_pkg.
interface ksh_res_if
    import ksh_pkg::*;
    ();
    logic             valid;
    logic             ready;
    t_status          status;
    logic [VAL_W-1:0] read_value;
    logic [VAL_W-1:0] top_value;
    logic             full_res;

    modport source (output valid, output status, output read_value, output top_value,
                    output full_res, input ready);
    modport sink   (input valid, input status, input read_value, input top_value,
                    input full_res, output ready);
endinterface

// ===== sv/ksh_cfg_if.sv =====
// Configuration write channel of the k-smallest max-heap: valid/ready plus k_in_use.
// Depends on ksh_pkg.
interface ksh_cfg_if
    import ksh_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [KCFG_W-1:0] k_in_use;

    modport source (output valid, output k_in_use, input ready);
    modport sink   (input valid, input k_in_use, output ready);
endinterface

// ===== sv/k_smallest_max_heap.sv =====
// Accept to result register: load, misuse and rejected offer go straight to the response
// state, read passes a data-capture state, an accepted offer sifts down with a read
// and a compare/write step per level. The heap-filling load adds a fetch and a load step
// per parent, both steps per level sunk, a read at a leaf. One transaction at a time.
// Reset: fill count cleared, k_in_use = 64, output empty; heap store is not cleared.
// Depends on ksh_pkg, the channel interfaces, ksh_heap_ram and the assertion macros.
`include "k_smallest_max_heap_macros.svh"

module k_smallest_max_heap
    import ksh_pkg::*;
#(
    parameter int MAX_K      = DEF_MAX_K,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ksh_item_if.sink   i_item,
    ksh_res_if.source  o_res,
    ksh_cfg_if.sink    i_cfg
);

    localparam int AW = $clog2(MAX_K);
    localparam int KW = $clog2(MAX_K + 1);
    localparam int CW = (KW > KCFG_W) ? KW : KCFG_W;
    localparam int IW = (KW > IDX_W) ? KW : IDX_W;
    localparam int NW = AW + 2;
    localparam int DW = VALUE_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_HSTART, S_HLOAD, S_READ, S_CMP, S_RDATA, S_RESP
    } t_state;

    // Control registers
    t_state            r_state, n_state;
    logic [KCFG_W-1:0] r_k, n_k;
    logic [KW-1:0]     r_fill, n_fill;
    logic              r_heap, n_heap;
    logic              r_out_valid, n_out_valid;
    // Working and payload registers
    logic [AW-1:0]     r_cur, n_cur;
    logic [AW-1:0]     r_hi, n_hi;
    logic [DW-1:0]     r_mov, n_mov;
    logic [DW-1:0]     r_top, n_top;
    t_status           r_status, n_status;
    logic [DW-1:0]     r_rd, n_rd;
    t_status           r_res_status, n_res_status;
    logic [DW-1:0]     r_res_read, n_res_read;
    logic [DW-1:0]     r_res_top, n_res_top;
    logic              r_res_full, n_res_full;

    // Memory port signals
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [DW-1:0]     w_wdata;
    logic [AW-1:0]     w_ra, w_rb;
    logic [DW-1:0]     w_rdata_a, w_rdata_b;

    // Derived values
    logic [CW-1:0]     w_k_wide;
    logic [KW-1:0]     w_k;
    logic [NW-1:0]     w_k_node;
    logic              w_full;
    logic [NW-1:0]     w_left, w_right;
    logic              w_left_ok, w_right_ok, w_pick_r;
    logic [DW-1:0]     w_child_val;
    logic [NW-1:0]     w_child_idx;
    logic [DW-1:0]     w_val_in;
    logic              w_in_acc;
    logic              w_out_free;

    ksh_heap_ram #(
        .DEPTH (MAX_K),
        .DW    (DW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_ra),
        .i_raddr_b (w_rb),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // Effective heap size: 0 acts as 1, above MAX_K acts as MAX_K
    always_comb begin
        w_k_wide = CW'(r_k);
        if (r_k == '0) begin
            w_k = KW'(1);
        end else if (w_k_wide > CW'(MAX_K)) begin
            w_k = KW'(MAX_K);
        end else begin
            w_k = KW'(w_k_wide);
        end
    end

    assign w_k_node   = NW'(w_k);
    assign w_full     = (r_fill >= w_k);
    assign w_val_in   = DW'(i_item.value);
    assign w_in_acc   = i_item.valid && i_item.ready;
    assign w_out_free = !r_out_valid || o_res.ready;

    // Children of the current node; right wins only if strictly greater
    assign w_left      = (NW'(r_cur) << 1) + NW'(1);
    assign w_right     = w_left + NW'(1);
    assign w_left_ok   = (w_left < w_k_node);
    assign w_right_ok  = (w_right < w_k_node);
    assign w_pick_r    = w_right_ok && (w_rdata_b > w_rdata_a);
    assign w_child_val = w_pick_r ? w_rdata_b : w_rdata_a;
    assign w_child_idx = w_pick_r ? w_right : w_left;

    // Handshakes
    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    // Output register drives the result channel
    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_res_status;
    assign o_res.read_value = VAL_W'(r_res_read);
    assign o_res.top_value  = VAL_W'(r_res_top);
    assign o_res.full_res   = r_res_full;

    // Next-state and memory control
    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_fill       = r_fill;
        n_heap       = r_heap;
        n_cur        = r_cur;
        n_hi         = r_hi;
        n_mov        = r_mov;
        n_status     = r_status;
        n_rd         = r_rd;
        n_out_valid  = r_out_valid;
        n_res_status = r_res_status;
        n_res_read   = r_res_read;
        n_res_top    = r_res_top;
        n_res_full   = r_res_full;
        w_we         = 1'b0;
        w_waddr      = r_cur;
        w_wdata      = r_mov;
        w_ra         = AW'(w_left);
        w_rb         = w_right_ok ? AW'(w_right) : AW'(w_left);

        // Result register drains on the output transaction
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                w_ra = AW'(i_item.index);
                if (w_in_acc) begin
                    n_status = ST_OK;
                    n_rd     = '0;
                    n_state  = S_RESP;
                    unique case (i_item.op)
                        OP_LOAD: begin
                            if (w_full) begin
                                n_status = ST_MISUSE;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = AW'(r_fill);
                                w_wdata = w_val_in;
                                n_fill  = r_fill + KW'(1);
                                // Last load: heapify from the last parent down
                                if ((r_fill + KW'(1) == w_k) && (w_k > KW'(1))) begin
                                    n_heap  = 1'b1;
                                    n_hi    = AW'((w_k >> 1) - KW'(1));
                                    n_state = S_HSTART;
                                end
                            end
                        end
                        OP_OFFER: begin
                            if (!w_full) begin
                                n_status = ST_MISUSE;
                            end else if (w_val_in > r_top) begin
                                n_status = ST_REJECT;
                            end else begin
                                n_cur   = '0;
                                n_mov   = w_val_in;
                                n_state = S_READ;
                            end
                        end
                        OP_READ: begin
                            if (IW'(i_item.index) >= IW'(w_k)) begin
                                n_status = ST_MISUSE;
                            end else begin
                                n_state = S_RDATA;
                            end
                        end
                        default: begin
                            n_status = ST_MISUSE;
                        end
                    endcase
                end
            end
            // Fetch the node that the next heapify sift starts from
            S_HSTART: begin
                w_ra    = r_hi;
                n_state = S_HLOAD;
            end
            S_HLOAD: begin
                n_mov   = w_rdata_a;
                n_cur   = r_hi;
                n_state = S_READ;
            end
            // Read both children, or settle the value at a leaf
            S_READ: begin
                if (w_left_ok) begin
                    n_state = S_CMP;
                end else begin
                    w_we = 1'b1;
                    if (r_heap && (r_hi != '0)) begin
                        n_hi    = r_hi - AW'(1);
                        n_state = S_HSTART;
                    end else begin
                        n_heap  = 1'b0;
                        n_state = S_RESP;
                    end
                end
            end
            // Move the larger child up, or settle the value here
            S_CMP: begin
                w_we = 1'b1;
                if (w_child_val <= r_mov) begin
                    if (r_heap && (r_hi != '0)) begin
                        n_hi    = r_hi - AW'(1);
                        n_state = S_HSTART;
                    end else begin
                        n_heap  = 1'b0;
                        n_state = S_RESP;
                    end
                end else begin
                    w_wdata = w_child_val;
                    n_cur   = AW'(w_child_idx);
                    n_state = S_READ;
                end
            end
            S_RDATA: begin
                n_rd    = w_rdata_a;
                n_state = S_RESP;
            end
            // Hand the result to the output register once it is free
            S_RESP: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_res_status = r_status;
                    n_res_read   = r_rd;
                    n_res_top    = r_top;
                    n_res_full   = w_full;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Configuration write clears the fill count
        if (i_cfg.valid && i_cfg.ready) begin
            n_k    = i_cfg.k_in_use;
            n_fill = '0;
        end
    end

    // Root mirror, follows every write to entry zero
    always_comb begin
        n_top = r_top;
        if (w_we && (w_waddr == '0)) begin
            n_top = w_wdata;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_hi         <= n_hi;
        r_mov        <= n_mov;
        r_top        <= n_top;
        r_status     <= n_status;
        r_rd         <= n_rd;
        r_res_status <= n_res_status;
        r_res_read   <= n_res_read;
        r_res_top    <= n_res_top;
        r_res_full   <= n_res_full;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= K_RESET;
            r_fill      <= '0;
            r_heap      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_fill      <= n_fill;
            r_heap      <= n_heap;
            r_out_valid <= n_out_valid;
        end
    end

    // Checks
    `KSH_ASSERT_NOW(a_fill_in_range, i_clk, i_rst_n, 1'b1, r_fill <= w_k, "fill count above k")
    `KSH_ASSERT_NOW(a_cmp_has_child, i_clk, i_rst_n, r_state == S_CMP, w_left < w_k_node,
        "compare step without a child")
    `KSH_ASSERT_NEXT(a_resp_waits, i_clk, i_rst_n,
        (r_state == S_RESP) && r_out_valid && !o_res.ready,
        (r_state == S_RESP) && r_out_valid, "result overwrote a pending output")

endmodule

// ===== sv/ksh_heap_ram.sv =====
// Heap store: one write port, two read ports, read data registered.
// No package dependencies; instantiated by k_smallest_max_heap.
module ksh_heap_ram #(
    parameter int DEPTH = 64,
    parameter int DW    = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [DW-1:0]            o_rdata_a,
    output logic [DW-1:0]            o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
